[sv/register_alu_execute_unit_top_macros.svh]
// Assertion macros for the register ALU execute unit.
`ifndef REGISTER_ALU_EXECUTE_UNIT_TOP_MACROS_SVH
`define REGISTER_ALU_EXECUTE_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define RAEU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset.
`define RAEU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/raeu_pkg.sv]
// Package: register file size, operation codes and payload types of the ALU execute unit.
`timescale 1ns / 1ps
`default_nettype none

package raeu_pkg;

	// Register file size
	localparam int unsigned NUM_REGS = 32;
	localparam int unsigned REG_AW   = $clog2(NUM_REGS);

	// Operation codes
	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SRL  = 3'd1;
	localparam logic [2:0] OP_AND  = 3'd2;
	localparam logic [2:0] OP_OR   = 3'd3;
	localparam logic [2:0] OP_NOR  = 3'd4;
	localparam logic [2:0] OP_HALT = 3'd5;

	// One instruction
	typedef struct packed {
		logic [2:0]         mode;
		logic               src1_is_reg;
		logic signed [31:0] src1_value;
		logic               src2_is_reg;
		logic signed [31:0] src2_value;
		logic               dest_is_reg;
		logic [4:0]         dest_index;
	} cmd_t;

	// One result
	typedef struct packed {
		logic               wrote;
		logic [4:0]         write_index;
		logic signed [31:0] write_value;
		logic               is_running;
	} res_t;

endpackage

`default_nettype wire

[sv/raeu_ram.sv]
// Generic RAM: one write port, two registered read ports, read-before-write.
`timescale 1ns / 1ps
`default_nettype none

module raeu_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered reads; a read at the write address returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

[sv/register_alu_execute_unit_top.sv]
// Top level: register ALU execute unit with register file, forwarding and result register.
// One instruction is taken per cycle and its result is offered from the result register:
// the register file RAM is read at the transfer edge, the ALU works in stage one, and the
// result register loads the outcome when stage one advances. Sustained throughput is one instruction
// per clock; the input stalls only while stage one holds an item and the result register waits
// on res_ready. A write-to-read forward path covers the instruction that follows directly.
// The register file reset is handled by per-register valid bits, so no clearing pass is
// needed and the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "register_alu_execute_unit_top_macros.svh"

module register_alu_execute_unit_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire raeu_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_ready,
	output raeu_pkg::res_t     res
);

	// Input side decode
	logic                            cmd_xfer;
	logic                            src1_ok;
	logic                            src2_ok;
	logic [raeu_pkg::REG_AW-1:0]     src1_addr;
	logic [raeu_pkg::REG_AW-1:0]     src2_addr;

	// Stage one
	logic                            v_s1;
	raeu_pkg::cmd_t                  cmd_s1;
	logic                            src1_rd_s1;
	logic                            src2_rd_s1;
	logic                            fwd1_s1;
	logic                            fwd2_s1;
	logic [31:0]                     fwd_data_s1;
	logic [31:0]                     rd1;
	logic [31:0]                     rd2;
	logic                            s1_adv;

	// Execute
	logic [31:0]                     op_a;
	logic [31:0]                     op_b;
	logic [31:0]                     alu_r;
	logic                            has_res;
	logic                            dest_ok;
	logic                            wrote_c;
	logic                            wr_en;
	logic [raeu_pkg::REG_AW-1:0]     wr_addr;
	raeu_pkg::res_t                  res_c;

	// Architectural state
	logic [raeu_pkg::NUM_REGS-1:0]   rf_vld_q;
	logic                            running_q;
	logic                            res_valid_q;
	raeu_pkg::res_t                  res_q;

	// Handshake
	assign s1_adv    = !res_valid_q || res_ready;
	assign cmd_ready = !v_s1 || s1_adv;
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Source index decode at the transfer
	assign src1_ok   = cmd.src1_is_reg && ($unsigned(cmd.src1_value) < 32'(raeu_pkg::NUM_REGS));
	assign src2_ok   = cmd.src2_is_reg && ($unsigned(cmd.src2_value) < 32'(raeu_pkg::NUM_REGS));
	assign src1_addr = cmd.src1_value[raeu_pkg::REG_AW-1:0];
	assign src2_addr = cmd.src2_value[raeu_pkg::REG_AW-1:0];

	// Register file
	raeu_ram #(
		.WIDTH (32),
		.DEPTH (raeu_pkg::NUM_REGS)
	) u_rf (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (alu_r),
		.re      (cmd_xfer),
		.raddr_a (src1_addr),
		.raddr_b (src2_addr),
		.rdata_a (rd1),
		.rdata_b (rd2)
	);

	// Stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_xfer) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage one payload, read qualifiers and forward from the write at the same edge
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_s1      <= cmd;
			src1_rd_s1  <= src1_ok && rf_vld_q[src1_addr];
			src2_rd_s1  <= src2_ok && rf_vld_q[src2_addr];
			fwd1_s1     <= wr_en && src1_ok && (src1_addr == wr_addr);
			fwd2_s1     <= wr_en && src2_ok && (src2_addr == wr_addr);
			fwd_data_s1 <= alu_r;
		end
	end

	// Operand select
	always_comb begin
		if (!cmd_s1.src1_is_reg) begin
			op_a = cmd_s1.src1_value;
		end else if (fwd1_s1) begin
			op_a = fwd_data_s1;
		end else if (src1_rd_s1) begin
			op_a = rd1;
		end else begin
			op_a = '0;
		end
		if (!cmd_s1.src2_is_reg) begin
			op_b = cmd_s1.src2_value;
		end else if (fwd2_s1) begin
			op_b = fwd_data_s1;
		end else if (src2_rd_s1) begin
			op_b = rd2;
		end else begin
			op_b = '0;
		end
	end

	// ALU
	always_comb begin
		alu_r   = '0;
		has_res = 1'b1;
		unique case (cmd_s1.mode)
			raeu_pkg::OP_ADD: begin
				alu_r = op_a + op_b;
			end
			raeu_pkg::OP_SRL: begin
				alu_r = (op_a < 32'd32) ? (op_b >> op_a[4:0]) : '0;
			end
			raeu_pkg::OP_AND: begin
				alu_r = op_a & op_b;
			end
			raeu_pkg::OP_OR: begin
				alu_r = op_a | op_b;
			end
			raeu_pkg::OP_NOR: begin
				alu_r = ~(op_a | op_b);
			end
			default: begin
				// halt and unused codes write nothing
				has_res = 1'b0;
			end
		endcase
	end

	// Writeback decision and result
	always_comb begin
		dest_ok     = 32'(cmd_s1.dest_index) < 32'(raeu_pkg::NUM_REGS);
		wrote_c     = has_res && cmd_s1.dest_is_reg && dest_ok;
		wr_en       = v_s1 && s1_adv && wrote_c;
		wr_addr     = raeu_pkg::REG_AW'(cmd_s1.dest_index);
		res_c.wrote       = wrote_c;
		res_c.write_index = wrote_c ? cmd_s1.dest_index : 5'd0;
		res_c.write_value = wrote_c ? alu_r : 32'd0;
		res_c.is_running  = (cmd_s1.mode == raeu_pkg::OP_HALT) ? 1'b0 : running_q;
	end

	// Register valid bits and running flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			running_q <= 1'b1;
		end else begin
			if (wr_en) begin
				rf_vld_q[wr_addr] <= 1'b1;
			end
			if (v_s1 && s1_adv && (cmd_s1.mode == raeu_pkg::OP_HALT)) begin
				running_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && v_s1) begin
			res_q <= res_c;
		end
	end

	// Checks
	`RAEU_ASSERT_IMP(a_nowrite_zero, res_valid_q && !res_q.wrote,
		(res_q.write_index == 5'd0) && (res_q.write_value == 32'd0),
		"result without write carries nonzero index or value")
	`RAEU_ASSERT_NXT(a_halt_sticky, !running_q, !running_q,
		"running flag set again without reset")
	`RAEU_ASSERT_IMP(a_ready_blocked, !cmd_ready, v_s1 && res_valid_q && !res_ready,
		"input stalled while the pipeline can move")
	`RAEU_ASSERT_IMP(a_write_moves, wr_en, v_s1 && s1_adv && (cmd_s1.mode <= raeu_pkg::OP_NOR),
		"register write without an advancing ALU instruction")

endmodule

`default_nettype wire

[test/testbench.sv]
// Testbench for the register ALU execute unit: shadow register file, scoreboard, random traffic.
`timescale 1ns / 1ps

module testbench;
	import raeu_pkg::*;

	// Mode codes the block leaves unused
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam logic [2:0] ALU_OPS [5] = '{OP_ADD, OP_SRL, OP_AND, OP_OR, OP_NOR};

	localparam int RANDOM_ITEMS  = 1550;
	localparam int LONG_HOLD_AT  = 400;   // receiver backs off here, sender keeps pushing
	localparam int NO_GAP_LEN    = 80;
	localparam int LONG_HOLD_LEN = 200;
	localparam int DRAIN_AT      = 900;   // sender waits for every result here
	localparam int QUIET_AT      = 1350;  // no idling from here on
	localparam int TAIL_CYCLES   = 12;

	// Shadow copy of the register file; predicts and checks each result
	class alu_shadow;
		logic [31:0] shadow_regs [NUM_REGS];
		logic        running;
		res_t        pending_results [$];
		int          mismatches;

		function new();
			foreach (shadow_regs[i])
				shadow_regs[i] = '0;
			running    = 1'b1;
			mismatches = 0;
		endfunction

		function logic [31:0] read_operand(logic is_reg, logic [31:0] raw);
			if (!is_reg)
				return raw;
			if (raw < NUM_REGS)
				return shadow_regs[int'(raw)];
			return '0;
		endfunction

		// Execute one accepted instruction against the shadow state
		function void take_instruction(cmd_t c);
			logic [31:0] a, b, r;
			logic        has_value;
			res_t        e;
			a = read_operand(c.src1_is_reg, c.src1_value);
			b = read_operand(c.src2_is_reg, c.src2_value);
			r = '0;
			has_value = 1'b1;
			case (c.mode)
				OP_ADD: r = a + b;
				OP_SRL: r = (a < 32) ? (b >> a[4:0]) : '0;
				OP_AND: r = a & b;
				OP_OR:  r = a | b;
				OP_NOR: r = ~(a | b);
				OP_HALT: begin
					running   = 1'b0;
					has_value = 1'b0;
				end
				default: has_value = 1'b0;
			endcase
			e = '0;
			if (has_value && c.dest_is_reg && c.dest_index < NUM_REGS) begin
				shadow_regs[c.dest_index] = r;
				e.wrote       = 1'b1;
				e.write_index = c.dest_index;
				e.write_value = r;
			end
			e.is_running = running;
			pending_results.push_back(e);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// Compare one result transfer with the oldest prediction
		task check_result(res_t got);
			res_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("result with none outstanding: %p", got));
				return;
			end
			e = pending_results.pop_front();
			if (got.wrote !== e.wrote)
				report($sformatf("wrote got %b exp %b", got.wrote, e.wrote));
			if (got.write_index !== e.write_index)
				report($sformatf("write_index got %0d exp %0d", got.write_index, e.write_index));
			if (got.write_value !== e.write_value)
				report($sformatf("write_value got %h exp %h", got.write_value, e.write_value));
			if (got.is_running !== e.is_running)
				report($sformatf("is_running got %b exp %b", got.is_running, e.is_running));
		endtask

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_ready;
	cmd_t  cmd       = '0;
	logic  res_valid;
	logic  res_ready = 1'b0;
	res_t  res;

	alu_shadow shadow = new();
	bit        quiet    = 1'b0;   // no idling on either side
	bit        gaps_on  = 1'b1;   // sender idling allowed
	bit        hold_req = 1'b0;   // ask receiver for one long hold-off

	register_alu_execute_unit_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic cmd_t instr(logic [2:0] op, logic s1r, logic [31:0] s1, logic s2r,
			logic [31:0] s2, logic dr, logic [4:0] di);
		cmd_t c;
		c.mode        = op;
		c.src1_is_reg = s1r;
		c.src1_value  = s1;
		c.src2_is_reg = s2r;
		c.src2_value  = s2;
		c.dest_is_reg = dr;
		c.dest_index  = di;
		return c;
	endfunction

	function automatic void pick_operand(output logic is_reg, output logic [31:0] val);
		logic [31:0] corners [4];
		corners = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
		is_reg = 1'($urandom_range(0, 1));
		if (is_reg) begin
			// mostly valid indexes, sometimes far out of range
			val = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 31);
		end else begin
			case ($urandom_range(0, 3))
				0: val = $urandom;
				1: val = $urandom_range(0, 40);
				2: val = -$urandom_range(1, 8);
				default: val = corners[$urandom_range(0, 3)];
			endcase
		end
	endfunction

	function automatic cmd_t random_instr();
		cmd_t c;
		int   pick;
		pick = $urandom_range(0, 63);
		if (pick < 60)
			c.mode = ALU_OPS[$urandom_range(0, 4)];
		else if (pick < 62)
			c.mode = OP_HALT;
		else
			c.mode = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
		pick_operand(c.src1_is_reg, c.src1_value);
		pick_operand(c.src2_is_reg, c.src2_value);
		c.dest_is_reg = ($urandom_range(0, 7) != 0);
		c.dest_index  = 5'($urandom_range(0, 31));
		return c;
	endfunction

	// One instruction transfer, with an occasional idle burst before it
	task automatic send_cmd(cmd_t c);
		if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		shadow.take_instruction(c);
	endtask

	// Hold the input back until every result is out
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				shadow.check_result(res);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: wrap-around add, corner operands, back-to-back dependencies
		send_cmd(instr(OP_ADD, 0, 32'h7fff_ffff, 0, 32'h0000_0001, 1, 5'd1));
		send_cmd(instr(OP_ADD, 0, 32'h8000_0000, 0, 32'hffff_ffff, 1, 5'd31));
		send_cmd(instr(OP_ADD, 1, 32'd1, 1, 32'd31, 1, 5'd2));
		send_cmd(instr(OP_SRL, 0, 32'd4, 0, 32'h8000_0000, 1, 5'd3));
		send_cmd(instr(OP_SRL, 0, 32'd31, 0, 32'hffff_ffff, 1, 5'd4));
		// shift amount out of range, above and below
		send_cmd(instr(OP_SRL, 0, 32'd32, 0, 32'hffff_ffff, 1, 5'd5));
		send_cmd(instr(OP_SRL, 0, 32'hffff_ffff, 0, 32'hffff_ffff, 1, 5'd6));
		send_cmd(instr(OP_SRL, 0, 32'd0, 1, 32'd1, 1, 5'd7));
		send_cmd(instr(OP_AND, 1, 32'd1, 0, 32'hff00_ff00, 1, 5'd8));
		send_cmd(instr(OP_OR, 1, 32'd8, 0, 32'h0f0f_0f0f, 1, 5'd9));
		send_cmd(instr(OP_NOR, 0, 32'd0, 0, 32'd0, 1, 5'd10));
		send_cmd(instr(OP_NOR, 1, 32'd10, 1, 32'd0, 1, 5'd0));
		// source index out of range reads zero
		send_cmd(instr(OP_ADD, 1, 32'd32, 1, 32'hffff_ffff, 1, 5'd11));
		// destination not a register
		send_cmd(instr(OP_ADD, 1, 32'h8000_0000, 0, 32'd5, 0, 5'd12));
		send_cmd(instr(OP_ADD, 1, 32'd31, 1, 32'd31, 1, 5'd31));
		send_cmd(instr(OP_ADD, 1, 32'd31, 0, 32'd1, 1, 5'd31));
		send_cmd(instr(OP_SRL, 1, 32'd3, 1, 32'd31, 1, 5'd31));
		// unused modes write nothing
		send_cmd(instr(OP_RSVD6, 0, 32'd1, 0, 32'd2, 1, 5'd3));
		send_cmd(instr(OP_RSVD7, 1, 32'd9, 1, 32'd9, 1, 5'd9));
		// halt, then instructions still execute with the flag cleared
		send_cmd(instr(OP_HALT, 1, 32'd1, 1, 32'd2, 1, 5'd3));
		send_cmd(instr(OP_ADD, 0, 32'd3, 0, 32'd4, 1, 5'd13));
		send_cmd(instr(OP_AND, 0, 32'hffff_ffff, 1, 32'd9, 1, 5'd14));
		send_cmd(instr(OP_OR, 0, 32'd0, 0, 32'd0, 1, 5'd15));
		send_cmd(instr(OP_HALT, 0, 32'd0, 0, 32'd0, 0, 5'd0));

		// Random traffic
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == LONG_HOLD_AT) begin
				hold_req = 1'b1;
				gaps_on  = 1'b0;
			end
			if (i == LONG_HOLD_AT + NO_GAP_LEN)
				gaps_on = 1'b1;
			if (i == DRAIN_AT)
				drain();
			if (i == QUIET_AT)
				quiet = 1'b1;
			send_cmd(random_instr());
		end

		// Wind down and let any stray result show up
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.outstanding() != 0)
			shadow.report($sformatf("%0d results never arrived", shadow.outstanding()));
		if (shadow.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[register_alu_execute_unit_top.f]
+incdir+sv
sv/raeu_pkg.sv
sv/raeu_ram.sv
sv/register_alu_execute_unit_top.sv
test/testbench.sv
